// ===== src/rcm_pkg.sv =====
// rcm_pkg: shared widths, command codes and register indexes for the
// request coalescing mailbox; no dependencies
`timescale 1ns / 1ps

package rcm_pkg;

    localparam int COORD_BITS   = 16;
    localparam int SEQ_BITS     = 32;
    localparam int TIME_BITS    = 48;
    localparam int SESSION_BITS = 32;
    localparam int ROOT_BITS    = 32;
    localparam int RADIUS_BITS  = 10;
    localparam int MS_BITS      = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    typedef enum logic [1:0] {
        CMD_BEGIN   = 2'd0,
        CMD_SUBMIT  = 2'd1,
        CMD_TAKE    = 2'd2,
        CMD_PUBLISH = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_RADIUS  = 2'd0,
        REG_WINDOW  = 2'd1,
        REG_BUDGET  = 2'd2,
        REG_UNUSED  = 2'd3
    } cfg_idx_t;

    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 10'd4;
    localparam logic [MS_BITS-1:0]     WINDOW_RESET = 16'd16;
    localparam logic [MS_BITS-1:0]     BUDGET_RESET = 16'd100;

endpackage

// ===== src/request_coalescing_mailbox.sv =====
// request_coalescing_mailbox: single-slot latest-wins request mailbox with
// session numbering, coalescing of near-duplicate submits and publish check
// depends on rcm_pkg
// path: a command is held in the input register, then in the result
//   register, which drives the m_ side; m_ready low holds it there
// throughput: one command per cycle; while a finished result waits for
//   m_ready the input register takes one more transfer, then s_ready drops
// reset: synchronous, active low aresetn; clears sessions, counters, valid
//   flags and both channels; registers return to radius 4, window 16 ms,
//   budget 100 ms
`timescale 1ns / 1ps

module request_coalescing_mailbox (
    input  logic                                aclk,
    input  logic                                aresetn,

    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rcm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [rcm_pkg::CFG_DATA_BITS-1:0]   cfg_data,

    // command channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_command,
    input  logic signed [rcm_pkg::COORD_BITS-1:0] s_point_x,
    input  logic signed [rcm_pkg::COORD_BITS-1:0] s_point_y,
    input  logic [rcm_pkg::ROOT_BITS-1:0]       s_root_id,
    input  logic signed [rcm_pkg::COORD_BITS-1:0] s_bounds_left,
    input  logic signed [rcm_pkg::COORD_BITS-1:0] s_bounds_top,
    input  logic signed [rcm_pkg::COORD_BITS-1:0] s_bounds_right,
    input  logic signed [rcm_pkg::COORD_BITS-1:0] s_bounds_bottom,
    input  logic [rcm_pkg::TIME_BITS-1:0]       s_now_ms,
    input  logic [rcm_pkg::SESSION_BITS-1:0]    s_check_session,
    input  logic [rcm_pkg::SEQ_BITS-1:0]        s_check_sequence,
    input  logic [rcm_pkg::TIME_BITS-1:0]       s_check_submitted_ms,

    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_flag,
    output logic [rcm_pkg::SESSION_BITS-1:0]    m_out_session,
    output logic [rcm_pkg::SEQ_BITS-1:0]        m_out_sequence,
    output logic signed [rcm_pkg::COORD_BITS-1:0] m_out_x,
    output logic signed [rcm_pkg::COORD_BITS-1:0] m_out_y,
    output logic [rcm_pkg::ROOT_BITS-1:0]       m_out_root,
    output logic signed [rcm_pkg::COORD_BITS-1:0] m_out_left,
    output logic signed [rcm_pkg::COORD_BITS-1:0] m_out_top,
    output logic signed [rcm_pkg::COORD_BITS-1:0] m_out_right,
    output logic signed [rcm_pkg::COORD_BITS-1:0] m_out_bottom,
    output logic [rcm_pkg::TIME_BITS-1:0]       m_out_submitted_ms
);

    import rcm_pkg::*;

    // ------------------------------------------------------------------
    // configuration registers, writes taken at any time
    // ------------------------------------------------------------------
    logic [RADIUS_BITS-1:0] radius_reg;
    logic [MS_BITS-1:0]     window_reg;
    logic [MS_BITS-1:0]     budget_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
            window_reg <= WINDOW_RESET;
            budget_reg <= BUDGET_RESET;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                REG_RADIUS: radius_reg <= cfg_data[RADIUS_BITS-1:0];
                REG_WINDOW: window_reg <= cfg_data;
                REG_BUDGET: budget_reg <= cfg_data;
                default: ;  // index beyond the list is dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input register: parts the two channels so one transfer can land
    // while the result register is still held by m_ready low
    // ------------------------------------------------------------------
    logic                          in_valid_reg;
    cmd_t                          in_cmd_reg;
    logic [COORD_BITS-1:0]         in_x_reg;
    logic [COORD_BITS-1:0]         in_y_reg;
    logic [ROOT_BITS-1:0]          in_root_reg;
    logic [COORD_BITS-1:0]         in_left_reg;
    logic [COORD_BITS-1:0]         in_top_reg;
    logic [COORD_BITS-1:0]         in_right_reg;
    logic [COORD_BITS-1:0]         in_bottom_reg;
    logic [TIME_BITS-1:0]          in_now_reg;
    logic [SESSION_BITS-1:0]       in_csess_reg;
    logic [SEQ_BITS-1:0]           in_cseq_reg;
    logic [TIME_BITS-1:0]          in_ctime_reg;

    logic out_valid_reg;
    logic advance;     // result register can take the processed command
    logic fire;        // command in the input register executes this cycle

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg    <= cmd_t'(s_command);
            in_x_reg      <= s_point_x;
            in_y_reg      <= s_point_y;
            in_root_reg   <= s_root_id;
            in_left_reg   <= s_bounds_left;
            in_top_reg    <= s_bounds_top;
            in_right_reg  <= s_bounds_right;
            in_bottom_reg <= s_bounds_bottom;
            in_now_reg    <= s_now_ms;
            in_csess_reg  <= s_check_session;
            in_cseq_reg   <= s_check_sequence;
            in_ctime_reg  <= s_check_submitted_ms;
        end
    end

    // ------------------------------------------------------------------
    // mailbox state
    // ------------------------------------------------------------------
    logic [SESSION_BITS-1:0] session_reg;
    logic [SEQ_BITS-1:0]     seq_cnt_reg;
    logic                    newest_valid_reg;
    logic [SEQ_BITS-1:0]     newest_seq_reg;
    logic [COORD_BITS-1:0]   newest_x_reg;
    logic [COORD_BITS-1:0]   newest_y_reg;
    logic [ROOT_BITS-1:0]    newest_root_reg;
    logic [TIME_BITS-1:0]    newest_time_reg;

    logic                    pend_valid_reg;
    logic [SESSION_BITS-1:0] pend_session_reg;
    logic [SEQ_BITS-1:0]     pend_seq_reg;
    logic [COORD_BITS-1:0]   pend_x_reg;
    logic [COORD_BITS-1:0]   pend_y_reg;
    logic [ROOT_BITS-1:0]    pend_root_reg;
    logic [COORD_BITS-1:0]   pend_left_reg;
    logic [COORD_BITS-1:0]   pend_top_reg;
    logic [COORD_BITS-1:0]   pend_right_reg;
    logic [COORD_BITS-1:0]   pend_bottom_reg;
    logic [TIME_BITS-1:0]    pend_time_reg;

    // ------------------------------------------------------------------
    // command datapath
    // ------------------------------------------------------------------
    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS:0]        adx, ady;
    logic [TIME_BITS:0]         age_newest, age_check;
    logic                       near_x, near_y, in_window, in_budget;
    logic                       merge;
    logic                       publish_ok;
    logic [SESSION_BITS-1:0]    session_next;
    logic [SEQ_BITS-1:0]        seq_next;

    always_comb begin
        // per-axis distance to the newest request, one bit wider for the sign
        dx  = $signed({in_x_reg[COORD_BITS-1], in_x_reg})
            - $signed({newest_x_reg[COORD_BITS-1], newest_x_reg});
        dy  = $signed({in_y_reg[COORD_BITS-1], in_y_reg})
            - $signed({newest_y_reg[COORD_BITS-1], newest_y_reg});
        adx = dx[COORD_BITS] ? (COORD_BITS+1)'(1) + ~dx : dx;
        ady = dy[COORD_BITS] ? (COORD_BITS+1)'(1) + ~dy : dy;
        near_x = adx <= {{(COORD_BITS+1-RADIUS_BITS){1'b0}}, radius_reg};
        near_y = ady <= {{(COORD_BITS+1-RADIUS_BITS){1'b0}}, radius_reg};

        // ages with a borrow bit; a clock that went back counts as too old
        age_newest = {1'b0, in_now_reg} - {1'b0, newest_time_reg};
        age_check  = {1'b0, in_now_reg} - {1'b0, in_ctime_reg};
        in_window  = !age_newest[TIME_BITS] &&
                     (age_newest[TIME_BITS-1:0] <=
                      {{(TIME_BITS-MS_BITS){1'b0}}, window_reg});
        in_budget  = !age_check[TIME_BITS] &&
                     (age_check[TIME_BITS-1:0] <=
                      {{(TIME_BITS-MS_BITS){1'b0}}, budget_reg});

        merge = newest_valid_reg && (newest_root_reg == in_root_reg) &&
                near_x && near_y && in_window;

        publish_ok = newest_valid_reg && (in_csess_reg == session_reg) &&
                     (in_cseq_reg == newest_seq_reg) && in_budget;

        // counters wrap past zero straight to one
        session_next = session_reg + 1'b1;
        if (session_next == '0) begin
            session_next = SESSION_BITS'(1);
        end
        seq_next = seq_cnt_reg + 1'b1;
        if (seq_next == '0) begin
            seq_next = SEQ_BITS'(1);
        end
    end

    // state update, only when a command executes; begin advances the session and
    // drops the valid flags since stale records are never read without them
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            session_reg      <= '0;
            seq_cnt_reg      <= '0;
            newest_valid_reg <= 1'b0;
            pend_valid_reg   <= 1'b0;
        end else if (fire) begin
            case (in_cmd_reg)
                CMD_BEGIN: begin
                    session_reg      <= session_next;
                    newest_valid_reg <= 1'b0;
                    pend_valid_reg   <= 1'b0;
                end
                CMD_SUBMIT: begin
                    if (!merge) begin
                        seq_cnt_reg      <= seq_next;
                        newest_valid_reg <= 1'b1;
                        pend_valid_reg   <= 1'b1;
                    end
                end
                CMD_TAKE: begin
                    pend_valid_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // newest and pending records, rewritten by an accepted submit
    always_ff @(posedge aclk) begin
        if (fire && (in_cmd_reg == CMD_SUBMIT) && !merge) begin
            newest_seq_reg   <= seq_next;
            newest_x_reg     <= in_x_reg;
            newest_y_reg     <= in_y_reg;
            newest_root_reg  <= in_root_reg;
            newest_time_reg  <= in_now_reg;
            pend_session_reg <= session_reg;
            pend_seq_reg     <= seq_next;
            pend_x_reg       <= in_x_reg;
            pend_y_reg       <= in_y_reg;
            pend_root_reg    <= in_root_reg;
            pend_left_reg    <= in_left_reg;
            pend_top_reg     <= in_top_reg;
            pend_right_reg   <= in_right_reg;
            pend_bottom_reg  <= in_bottom_reg;
            pend_time_reg    <= in_now_reg;
        end
    end

    // ------------------------------------------------------------------
    // result register; fields a command does not produce read zero
    // ------------------------------------------------------------------
    logic                    flag_next;
    logic [SESSION_BITS-1:0] session_out_next;
    logic [SEQ_BITS-1:0]     seq_out_next;
    logic [COORD_BITS-1:0]   x_next, y_next, left_next, top_next;
    logic [COORD_BITS-1:0]   right_next, bottom_next;
    logic [ROOT_BITS-1:0]    root_next;
    logic [TIME_BITS-1:0]    time_next;

    always_comb begin
        flag_next        = 1'b0;
        session_out_next = '0;
        seq_out_next     = '0;
        x_next           = '0;
        y_next           = '0;
        root_next        = '0;
        left_next        = '0;
        top_next         = '0;
        right_next       = '0;
        bottom_next      = '0;
        time_next        = '0;
        case (in_cmd_reg)
            CMD_BEGIN: begin
                flag_next        = 1'b1;
                session_out_next = session_next;
            end
            CMD_SUBMIT: begin
                if (!merge) begin
                    flag_next    = 1'b1;
                    seq_out_next = seq_next;
                end
            end
            CMD_TAKE: begin
                if (pend_valid_reg) begin
                    flag_next        = 1'b1;
                    session_out_next = pend_session_reg;
                    seq_out_next     = pend_seq_reg;
                    x_next           = pend_x_reg;
                    y_next           = pend_y_reg;
                    root_next        = pend_root_reg;
                    left_next        = pend_left_reg;
                    top_next         = pend_top_reg;
                    right_next       = pend_right_reg;
                    bottom_next      = pend_bottom_reg;
                    time_next        = pend_time_reg;
                end
            end
            CMD_PUBLISH: begin
                flag_next = publish_ok;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_flag             <= flag_next;
            m_out_session      <= session_out_next;
            m_out_sequence     <= seq_out_next;
            m_out_x            <= x_next;
            m_out_y            <= y_next;
            m_out_root         <= root_next;
            m_out_left         <= left_next;
            m_out_top          <= top_next;
            m_out_right        <= right_next;
            m_out_bottom       <= bottom_next;
            m_out_submitted_ms <= time_next;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

// ===== src/rcm_checker.sv =====
// rcm_checker: port-level assertions for request_coalescing_mailbox, bound
// to the top level; depends on rcm_pkg
`timescale 1ns / 1ps

module rcm_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_ready,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic                                  m_flag,
    input logic [rcm_pkg::SESSION_BITS-1:0]      m_out_session,
    input logic [rcm_pkg::SEQ_BITS-1:0]          m_out_sequence,
    input logic [rcm_pkg::ROOT_BITS-1:0]         m_out_root,
    input logic [rcm_pkg::TIME_BITS-1:0]         m_out_submitted_ms
);

    import rcm_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_flag)
            && $stable(m_out_sequence) && $stable(m_out_session))
        else $error("result changed while stalled");

    // reset empties the result side
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a negative result carries no record
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_flag |-> m_out_session == '0 && m_out_sequence == '0
            && m_out_root == '0 && m_out_submitted_ms == '0)
        else $error("negative result carries data");

    // with an empty result register the input side is never blocked
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

endmodule

bind request_coalescing_mailbox rcm_checker u_rcm_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_flag             (m_flag),
    .m_out_session      (m_out_session),
    .m_out_sequence     (m_out_sequence),
    .m_out_root         (m_out_root),
    .m_out_submitted_ms (m_out_submitted_ms)
);
